>>> hw/rtl/tksn_pkg.sv
// shared types and constants for the top-k weight select and normalize block
// back-end state encoding and divider request/response structs
// no dependencies
package tksn_pkg;

    localparam int WORD_W     = 16;
    localparam int K_W        = 4;
    localparam int K_RESET    = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int NUM_W      = 32;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> hw/rtl/tksn_in_if.sv
// valid/ready channel carrying one influence word
// uses tksn_pkg for field widths
interface tksn_in_if;
    logic                        valid;
    logic                        ready;
    logic [tksn_pkg::WORD_W-1:0] bone_index;
    logic [tksn_pkg::WORD_W-1:0] weight;
    logic                        has_influence;
    logic                        vertex_end;

    modport source (output valid, bone_index, weight, has_influence, vertex_end, input ready);
    modport sink   (input valid, bone_index, weight, has_influence, vertex_end, output ready);
endinterface

>>> hw/rtl/tksn_out_if.sv
// valid/ready channel carrying one normalized slot word
// uses tksn_pkg for field widths
interface tksn_out_if;
    logic                        valid;
    logic                        ready;
    logic [tksn_pkg::WORD_W-1:0] out_bone;
    logic [tksn_pkg::WORD_W-1:0] out_weight;
    logic                        slot_last;

    modport source (output valid, out_bone, out_weight, slot_last, input ready);
    modport sink   (input valid, out_bone, out_weight, slot_last, output ready);
endinterface

>>> hw/rtl/tksn_front.sv
// front end: accepts influence words into a short queue for the back end
// depends on tksn_pkg and tksn_in_if
module tksn_front (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tksn_in_if.sink    i_in,
    tksn_in_if.source  o_q
);

    localparam int ITEM_W = 2 * tksn_pkg::WORD_W + 2;

    logic [ITEM_W-1:0]            r_mem [tksn_pkg::FIFO_DEPTH];
    logic [tksn_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [tksn_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [tksn_pkg::FIFO_AW:0]   r_fill;
    logic                         push;
    logic                         pop;
    logic [ITEM_W-1:0]            rd_word;

    assign i_in.ready = (r_fill != (tksn_pkg::FIFO_AW + 1)'(tksn_pkg::FIFO_DEPTH));
    assign o_q.valid  = (r_fill != '0);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = o_q.valid && o_q.ready;
    assign rd_word    = r_mem[r_rd_ptr];

    assign o_q.bone_index    = rd_word[ITEM_W-1 -: tksn_pkg::WORD_W];
    assign o_q.weight        = rd_word[2 +: tksn_pkg::WORD_W];
    assign o_q.has_influence = rd_word[1];
    assign o_q.vertex_end    = rd_word[0];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= {i_in.bone_index, i_in.weight, i_in.has_influence,
                                i_in.vertex_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10: begin
                    r_fill <= r_fill + 1'b1;
                end
                2'b01: begin
                    r_fill <= r_fill - 1'b1;
                end
                default: begin
                    r_fill <= r_fill;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/tksn_div.sv
// restoring divider, one quotient bit per cycle, 16-bit quotient
// depends on tksn_pkg for request/response structs
module tksn_div #(
    parameter int DEN_W = 19
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tksn_pkg::t_div_req  i_req,
    input  logic [DEN_W-1:0]    i_den,
    output tksn_pkg::t_div_rsp  o_rsp
);

    logic [DEN_W-1:0]                r_rem;
    logic [tksn_pkg::WORD_W-1:0]     r_q;
    logic [tksn_pkg::DIV_CNT_W-1:0]  r_step;
    logic                            r_busy;
    logic                            r_done;
    logic [DEN_W:0]                  trial;
    logic [DEN_W:0]                  diff;
    logic                            fits;

    assign trial = {r_rem, r_q[tksn_pkg::WORD_W-1]};
    assign diff  = trial - {1'b0, i_den};
    assign fits  = (trial >= {1'b0, i_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= DEN_W'(i_req.num[tksn_pkg::NUM_W-1 -: tksn_pkg::WORD_W]);
                r_q    <= i_req.num[tksn_pkg::WORD_W-1:0];
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_q    <= {r_q[tksn_pkg::WORD_W-2:0], fits};
                r_step <= r_step + 1'b1;
                if (r_step == tksn_pkg::DIV_CNT_W'(tksn_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> hw/rtl/tksn_back.sv
// back end: sorted top-k insertion, kept-sum accumulation and slot sequencing
// depends on tksn_pkg, tksn_in_if, tksn_out_if; drives the divider in tksn_div
module tksn_back #(
    parameter int MAX_SLOTS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [tksn_pkg::K_W-1:0]   i_cfg_wr_data,
    tksn_in_if.sink                    i_q,
    tksn_out_if.source                 o_out,
    output tksn_pkg::t_div_req         o_div_req,
    output logic [tksn_pkg::WORD_W + $clog2(MAX_SLOTS)-1:0] o_div_den,
    input  tksn_pkg::t_div_rsp         i_div_rsp
);

    localparam int W      = tksn_pkg::WORD_W;
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int SUM_W  = W + $clog2(MAX_SLOTS);

    tksn_pkg::t_state            r_state;
    tksn_pkg::t_state            n_state;
    logic [tksn_pkg::K_W-1:0]    r_cfg;
    logic [W-1:0]                r_kb [MAX_SLOTS];
    logic [W-1:0]                r_kw [MAX_SLOTS];
    logic [CNT_W-1:0]            r_cnt;
    logic [CNT_W-1:0]            r_k;
    logic [CNT_W-1:0]            r_used;
    logic [CNT_W-1:0]            r_i;
    logic [SUM_W-1:0]            r_sum;
    logic [W-1:0]                r_ob;
    logic [W-1:0]                r_ow;
    logic                        r_last;

    logic [MAX_SLOTS-1:0]        ge;
    logic [MAX_SLOTS-1:0]        pge;
    logic [W-1:0]                sh_b  [MAX_SLOTS];
    logic [W-1:0]                sh_w  [MAX_SLOTS];
    logic [W-1:0]                ins_b [MAX_SLOTS];
    logic [W-1:0]                ins_w [MAX_SLOTS];
    logic                        ins;
    logic [CNT_W-1:0]            cnt_ins;
    logic [CNT_W-1:0]            cnt_after;
    logic [CNT_W-1:0]            eff_k;
    logic [CNT_W-1:0]            used_new;
    logic                        pop;
    logic                        more;
    logic [W-1:0]                kb_i;
    logic [W-1:0]                kw_i;

    assign pop  = i_q.valid && i_q.ready;
    assign more = (r_i < r_used);
    assign kb_i = r_kb[r_i[SLOT_W-1:0]];
    assign kw_i = r_kw[r_i[SLOT_W-1:0]];

    // ordered insert, ties keep arrival order
    always_comb begin
        for (int j = 0; j < MAX_SLOTS; j++) begin
            ge[j] = (CNT_W'(j) < r_cnt) && (r_kw[j] >= i_q.weight);
        end
        pge[0]  = 1'b1;
        sh_b[0] = i_q.bone_index;
        sh_w[0] = i_q.weight;
        for (int j = 1; j < MAX_SLOTS; j++) begin
            pge[j]  = ge[j-1];
            sh_b[j] = r_kb[j-1];
            sh_w[j] = r_kw[j-1];
        end
        for (int j = 0; j < MAX_SLOTS; j++) begin
            if (ge[j]) begin
                ins_b[j] = r_kb[j];
                ins_w[j] = r_kw[j];
            end else if (pge[j]) begin
                ins_b[j] = i_q.bone_index;
                ins_w[j] = i_q.weight;
            end else begin
                ins_b[j] = sh_b[j];
                ins_w[j] = sh_w[j];
            end
        end
        ins       = i_q.has_influence && (i_q.weight != '0) && !ge[MAX_SLOTS-1];
        cnt_ins   = (r_cnt == CNT_W'(MAX_SLOTS)) ? r_cnt : r_cnt + 1'b1;
        cnt_after = ins ? cnt_ins : r_cnt;
        if (r_cfg == '0) begin
            eff_k = CNT_W'(1);
        end else if (32'(r_cfg) > MAX_SLOTS) begin
            eff_k = CNT_W'(MAX_SLOTS);
        end else begin
            eff_k = CNT_W'(r_cfg);
        end
        used_new = (cnt_after < eff_k) ? cnt_after : eff_k;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tksn_pkg::S_IDLE: begin
                if (pop && i_q.vertex_end) begin
                    n_state = tksn_pkg::S_SUM;
                end
            end
            tksn_pkg::S_SUM: begin
                if (!more) begin
                    n_state = tksn_pkg::S_PREP;
                end
            end
            tksn_pkg::S_PREP: begin
                n_state = more ? tksn_pkg::S_DIV : tksn_pkg::S_OUT;
            end
            tksn_pkg::S_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = tksn_pkg::S_OUT;
                end
            end
            tksn_pkg::S_OUT: begin
                if (o_out.ready) begin
                    n_state = r_last ? tksn_pkg::S_IDLE : tksn_pkg::S_PREP;
                end
            end
            default: begin
                n_state = tksn_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        i_q.ready        = (r_state == tksn_pkg::S_IDLE);
        o_out.valid      = (r_state == tksn_pkg::S_OUT);
        o_out.out_bone   = r_ob;
        o_out.out_weight = r_ow;
        o_out.slot_last  = r_last;
        o_div_req.start  = (r_state == tksn_pkg::S_PREP) && more;
        // w * 65535 as (w << 16) - w
        o_div_req.num    = {kw_i, {W{1'b0}}} - {{W{1'b0}}, kw_i};
        o_div_den        = r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tksn_pkg::S_IDLE;
            r_cfg   <= tksn_pkg::K_W'(tksn_pkg::K_RESET);
            r_cnt   <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            case (r_state)
                tksn_pkg::S_IDLE: begin
                    if (pop) begin
                        if (ins) begin
                            for (int j = 0; j < MAX_SLOTS; j++) begin
                                r_kb[j] <= ins_b[j];
                                r_kw[j] <= ins_w[j];
                            end
                        end
                        r_cnt <= cnt_after;
                        if (i_q.vertex_end) begin
                            r_k    <= eff_k;
                            r_used <= used_new;
                            r_i    <= '0;
                            r_sum  <= '0;
                        end
                    end
                end
                tksn_pkg::S_SUM: begin
                    if (more) begin
                        r_sum <= r_sum + SUM_W'(kw_i);
                        r_i   <= r_i + 1'b1;
                    end else begin
                        r_i <= '0;
                    end
                end
                tksn_pkg::S_PREP: begin
                    r_last <= (r_i == r_k - 1'b1);
                    r_ob   <= more ? kb_i : '0;
                    r_ow   <= '0;
                end
                tksn_pkg::S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_ow <= i_div_rsp.quot;
                    end
                end
                tksn_pkg::S_OUT: begin
                    if (o_out.ready) begin
                        if (r_last) begin
                            r_cnt <= '0;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                default: begin
                    r_i <= r_i;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/topk_weight_select_normalize.sv
// top level: keeps the heaviest influences of each vertex and emits them normalized
// depends on tksn_pkg, tksn_in_if, tksn_out_if, tksn_front, tksn_back, tksn_div
//
// i_in carries one influence word per handshake (bone, weight, has_influence,
// vertex_end). zero weights are dropped; up to MAX_SLOTS entries are kept in
// descending weight order, earlier arrival first on equal weights.
// on the word with vertex_end the block emits exactly K words on o_out, K being
// i_cfg_wr_data clamped to 1..MAX_SLOTS, each weight scaled to
// floor(w * 65535 / emitted sum), empty slots padded with bone 0 and weight 0,
// slot_last set on the final one. i_cfg_wr_en writes K; reset value is 4.
// the back end takes a word without vertex_end straight into the kept list. on a
// vertex end it sums the weights of the slots it emits, then for each kept slot
// prepares, runs the bit-serial divider and outputs it, and for each padding
// slot prepares and outputs it, waiting while the receiver holds ready low.
// a four-word queue in front accepts words while results wait, until it is full.
// when the receiver stalls, the current result holds on o_out until taken.
// synchronous reset clears the queue, the kept list and sets K to 4.
module topk_weight_select_normalize #(
    parameter int MAX_SLOTS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [tksn_pkg::K_W-1:0]  i_cfg_wr_data,
    tksn_in_if.sink                   i_in,
    tksn_out_if.source                o_out
);

    localparam int SUM_W = tksn_pkg::WORD_W + $clog2(MAX_SLOTS);

    tksn_in_if           q_if ();
    tksn_pkg::t_div_req  div_req;
    tksn_pkg::t_div_rsp  div_rsp;
    logic [SUM_W-1:0]    div_den;

    tksn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_q     (q_if.source)
    );

    tksn_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q           (q_if.sink),
        .o_out         (o_out),
        .o_div_req     (div_req),
        .o_div_den     (div_den),
        .i_div_rsp     (div_rsp)
    );

    tksn_div #(
        .DEN_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_den   (div_den),
        .o_rsp   (div_rsp)
    );

endmodule
